### sv/acl_first_match_checker_macros.svh
// ----------------------------------------------------------------------------
// ACL checker assertion macros
// Concurrent assertion wrappers shared by the checker RTL. Define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef ACL_FIRST_MATCH_CHECKER_MACROS_SVH
`define ACL_FIRST_MATCH_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

// Check on every clock edge outside reset
`define ACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define ACL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ACL_ASSERT(lbl, prop, msg)
`define ACL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### sv/acl_pkg.sv
// ----------------------------------------------------------------------------
// ACL checker package
// Command, tag, status and state codes plus the structs shared between the
// top level and the table cells.
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int ID_W      = 32;
  localparam int PERM_W    = 32;
  localparam int TAG_W     = 2;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    TAG_USER  = 2'd0,
    TAG_GROUP = 2'd1,
    TAG_OTHER = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DENIED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

  // One table entry as held in a cell
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
    logic [PERM_W-1:0] perm;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic advance;   // move the search token one cell
    logic clear;     // drop token and visited marks
    logic shift_r;   // insert at the front, everything moves back
    logic shift_l;   // close the gap at the matched cell
  } cell_ctl_t;

  // Lookup key broadcast to every cell
  typedef struct packed {
    logic              is_remove;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   eid;
    logic [ID_W-1:0]   uid;
    logic [ID_W-1:0]   gid;
    logic [PERM_W-1:0] want;
  } query_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic tok;    // search token sits here
    logic hit;    // token sits on a matching live entry
    logic grant;  // hit and the stored bits cover the request
    logic stop;   // token reached the first empty cell
  } cell_stat_t;

endpackage

### sv/acl_if.sv
// ----------------------------------------------------------------------------
// ACL checker channels
// Valid/ready channel interfaces for the request and result transactions.
// ----------------------------------------------------------------------------
interface acl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  tag;
  logic [31:0] entry_id;
  logic [31:0] perm_bits;
  logic [31:0] user_id;
  logic [31:0] group_id;
  logic [31:0] want_mask;

  modport source (
    output valid, command, tag, entry_id, perm_bits, user_id, group_id, want_mask,
    input  ready
  );

  modport sink (
    input  valid, command, tag, entry_id, perm_bits, user_id, group_id, want_mask,
    output ready
  );
endinterface

interface acl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] entry_count;

  modport source (
    output valid, status, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, entry_count,
    output ready
  );
endinterface

### sv/acl_cell.sv
// ----------------------------------------------------------------------------
// ACL table cell
// Holds one table slot, compares it against the broadcast key when the
// search token arrives, and shifts its entry to or from its neighbors.
// ----------------------------------------------------------------------------
module acl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  acl_pkg::cell_ctl_t ctl,
  input  acl_pkg::query_t    qry,
  input  logic [CNT_W-1:0]   held,
  input  acl_pkg::entry_t    left_ent,
  input  acl_pkg::entry_t    right_ent,
  input  logic               tok_in,
  output logic               tok_out,
  output acl_pkg::entry_t    ent,
  output acl_pkg::cell_stat_t stat
);
  import acl_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   tok_r, tok_nxt;
  logic   pass_r, pass_nxt;
  logic   live;
  logic   mat_rm, mat_ck, match;
  logic   hit;

  // Slot is live when it lies below the fill count
  assign live = (held > CNT_W'(IDX));

  // Compare against the key for the current command
  always_comb begin
    mat_rm = (ent_r.tag == qry.tag) && (ent_r.id == qry.eid);
    mat_ck = ((ent_r.tag == TAG_USER)  && (ent_r.id == qry.uid)) ||
             ((ent_r.tag == TAG_GROUP) && (ent_r.id == qry.gid)) ||
             (ent_r.tag == TAG_OTHER);
    match  = qry.is_remove ? mat_rm : mat_ck;
  end

  assign hit     = tok_r & live & match;
  assign tok_out = tok_r & live & ~match;

  // Advance the token; hold it on a hit so the commit knows the spot
  always_comb begin
    if (ctl.clear) begin
      tok_nxt  = 1'b0;
      pass_nxt = 1'b0;
    end else if (ctl.advance) begin
      tok_nxt  = tok_in | hit;
      pass_nxt = pass_r | tok_out;
    end else begin
      tok_nxt  = tok_r;
      pass_nxt = pass_r;
    end
  end

  // Shift entries: back on insert, forward from the matched cell on delete
  always_comb begin
    if (ctl.shift_r) begin
      ent_nxt = left_ent;
    end else if (ctl.shift_l && !pass_r) begin
      ent_nxt = right_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      pass_r <= 1'b0;
    end else begin
      tok_r  <= tok_nxt;
      pass_r <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent        = ent_r;
  assign stat.tok   = tok_r;
  assign stat.hit   = hit;
  assign stat.grant = hit & ((ent_r.perm & qry.want) == qry.want);
  assign stat.stop  = tok_r & ~live;

endmodule

### sv/acl_first_match_checker.sv
// ----------------------------------------------------------------------------
// ACL first-match checker
// Ordered access-control table, newest entry first, with add, remove and
// first-match permission check.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, slot 0 the newest. An add, an
// unused command or a root check (user id 0) goes from accept straight to
// the finish state. A remove or a non-root check sends a search token down
// the row, one cell per cycle, until it reaches the first match or the
// first empty cell; on a full table with no match the walk ends at the last
// cell. One transaction is in flight at a time; the result sits in an output
// register so the next request is taken while it waits. Table updates
// (insert shift, delete close-up) happen in the single cycle the result is
// loaded.
`include "acl_first_match_checker_macros.svh"

module acl_first_match_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  acl_in_if.sink    in_chan,
  acl_out_if.source out_chan
);
  import acl_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  fsm_state_t state_r, state_nxt;

  // Captured request
  logic [1:0]        cmd_r;
  logic [TAG_W-1:0]  tag_r;
  logic [ID_W-1:0]   eid_r;
  logic [PERM_W-1:0] perm_r;
  logic [ID_W-1:0]   uid_r;
  logic [ID_W-1:0]   gid_r;
  logic [PERM_W-1:0] want_r;

  status_t           res_st_r, res_st_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic       in_ready, acc, start, out_free, commit, table_full;
  cell_ctl_t  ctl;
  query_t     qry;
  entry_t     new_ent;
  entry_t     ent_q  [TABLE_DEPTH];
  cell_stat_t stat_q [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]   tok_link;
  logic [TABLE_DEPTH-1:0] tok_vec;
  logic any_hit, any_grant, any_end;

  assign table_full = (held_r == CNT_W'(TABLE_DEPTH));
  assign out_free   = !out_valid_r || out_chan.ready;
  assign acc        = in_chan.valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = start ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (any_hit || any_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    start       = 1'b0;
    commit      = 1'b0;
    ctl.advance = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        start       = in_chan.valid &&
                      ((in_chan.command == CMD_REMOVE) ||
                       ((in_chan.command == CMD_CHECK) && (in_chan.user_id != '0)));
        ctl.advance = start;
      end
      S_SCAN: begin
        ctl.advance = 1'b1;
      end
      S_FINISH: begin
        commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    ctl.clear   = commit;
    ctl.shift_r = commit && (cmd_r == CMD_ADD) && (res_st_r == ST_OK);
    ctl.shift_l = commit && (cmd_r == CMD_REMOVE) && (res_st_r == ST_OK);
  end

  // Pending status: decided at accept or at the end of the walk
  always_comb begin
    res_st_nxt = res_st_r;
    if (acc) begin
      case (in_chan.command)
        CMD_ADD: res_st_nxt = table_full ? ST_FULL : ST_OK;
        default: res_st_nxt = ST_OK;
      endcase
    end else if (state_r == S_SCAN) begin
      if (any_hit) begin
        if (cmd_r == CMD_REMOVE) begin
          res_st_nxt = ST_OK;
        end else begin
          res_st_nxt = any_grant ? ST_OK : ST_DENIED;
        end
      end else if (any_end) begin
        if (cmd_r == CMD_REMOVE) begin
          res_st_nxt = ST_NOT_FOUND;
        end else begin
          res_st_nxt = (want_r == '0) ? ST_OK : ST_DENIED;
        end
      end
    end
  end

  // Fill count follows the committed table update
  always_comb begin
    held_nxt = held_r;
    if (ctl.shift_r) begin
      held_nxt = held_r + CNT_W'(1);
    end else if (ctl.shift_l) begin
      held_nxt = held_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture request fields and load the result register
  always_ff @(posedge clk) begin
    res_st_r <= res_st_nxt;
    if (acc) begin
      cmd_r  <= in_chan.command;
      tag_r  <= in_chan.tag;
      eid_r  <= in_chan.entry_id;
      perm_r <= in_chan.perm_bits;
      uid_r  <= in_chan.user_id;
      gid_r  <= in_chan.group_id;
      want_r <= in_chan.want_mask;
    end
    if (commit) begin
      out_status_r <= res_st_r;
      out_count_r  <= OUT_CNT_W'(held_nxt);
    end
  end

  // Broadcast key and new entry
  always_comb begin
    qry.is_remove = (cmd_r == CMD_REMOVE);
    qry.tag       = tag_r;
    qry.eid       = eid_r;
    qry.uid       = uid_r;
    qry.gid       = gid_r;
    qry.want      = want_r;
    new_ent.tag   = tag_r;
    new_ent.id    = eid_r;
    new_ent.perm  = perm_r;
  end

  assign tok_link[0] = start;

  // Row of table cells
  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    entry_t left_ent, right_ent;

    if (gi == 0) begin : g_head
      assign left_ent = new_ent;
    end else begin : g_body
      assign left_ent = ent_q[gi-1];
    end

    if (gi == TABLE_DEPTH - 1) begin : g_tail
      assign right_ent = ent_q[gi];
    end else begin : g_mid
      assign right_ent = ent_q[gi+1];
    end

    acl_cell #(
      .IDX   (gi),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .qry       (qry),
      .held      (held_r),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .tok_in    (tok_link[gi]),
      .tok_out   (tok_link[gi+1]),
      .ent       (ent_q[gi]),
      .stat      (stat_q[gi])
    );

    assign tok_vec[gi] = stat_q[gi].tok;
  end

  // Collect cell status; a token leaving the last cell ends the walk
  always_comb begin
    any_hit   = 1'b0;
    any_grant = 1'b0;
    any_end   = tok_link[TABLE_DEPTH];
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any_hit   = any_hit   | stat_q[i].hit;
      any_grant = any_grant | stat_q[i].grant;
      any_end   = any_end   | stat_q[i].stop;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_count = out_count_r;

  // Assertions
  `ACL_ASSERT(a_one_token, $onehot0(tok_vec), "more than one search token in the row")
  `ACL_ASSERT(a_idle_no_token, (state_r == S_IDLE) |-> (tok_vec == '0), "token left behind in idle")
  `ACL_ASSERT(a_count_on_commit, (held_r != $past(held_r)) |-> $past(commit), "count moved without a commit")
  `ACL_ASSERT(a_count_bound, held_r <= CNT_W'(TABLE_DEPTH), "fill count above table depth")
  `ACL_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule
